/* sv/amp_pkg.sv */
`default_nettype none
package amp_pkg;

    // pattern geometry
    localparam int MaxPattern = 16;
    localparam int ByteW      = 8;
    localparam int StateW     = $clog2(MaxPattern + 1);
    localparam int LenW       = 5;
    localparam int CountW     = 32;

    // register port geometry
    localparam int DataW      = 64;
    localparam int AddrW      = 5;
    localparam int RegIdxW    = 2;
    localparam int RegLsb     = 3;

    // register indexes
    localparam logic [RegIdxW-1:0] RegPatLow  = 2'd0;
    localparam logic [RegIdxW-1:0] RegPatHigh = 2'd1;
    localparam logic [RegIdxW-1:0] RegPatLen  = 2'd2;

    localparam logic [LenW-1:0] LenReset = 5'd1;

    typedef logic [MaxPattern-1:0][ByteW-1:0] t_pat;

    // bit j of row q: prefix of length j is a suffix of prefix of length q
    typedef logic [MaxPattern-1:0] t_row;
    typedef logic [MaxPattern:0][MaxPattern-1:0] t_border;

    typedef struct packed {
        t_pat            pat;
        logic [LenW-1:0] len;
    } t_cfg;

    typedef struct packed {
        t_border           rows;
        logic [StateW-1:0] m;
    } t_tbl;

endpackage
`default_nettype wire

/* sv/amp_cfg.sv */
`default_nettype none
module amp_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [amp_pkg::AddrW-1:0]  paddr,
    input  wire logic [amp_pkg::DataW-1:0]  pwdata,
    output logic      [amp_pkg::DataW-1:0]  prdata,
    output logic                            pready,
    output amp_pkg::t_cfg                   o_cfg
);

    logic [amp_pkg::DataW-1:0]   r_pat_low;
    logic [amp_pkg::DataW-1:0]   r_pat_high;
    logic [amp_pkg::LenW-1:0]    r_len;
    logic [amp_pkg::RegIdxW-1:0] reg_idx;
    logic                        wr_en;

    assign reg_idx = paddr[amp_pkg::RegLsb +: amp_pkg::RegIdxW];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= amp_pkg::LenReset;
        end else if (wr_en) begin
            case (reg_idx)
                amp_pkg::RegPatLow:  r_pat_low  <= pwdata;
                amp_pkg::RegPatHigh: r_pat_high <= pwdata;
                amp_pkg::RegPatLen:  r_len      <= pwdata[amp_pkg::LenW-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            amp_pkg::RegPatLow:  prdata = r_pat_low;
            amp_pkg::RegPatHigh: prdata = r_pat_high;
            amp_pkg::RegPatLen:  prdata = {{(amp_pkg::DataW - amp_pkg::LenW){1'b0}}, r_len};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.pat = {r_pat_high, r_pat_low};
    assign o_cfg.len = r_len;

endmodule
`default_nettype wire

/* sv/amp_border.sv */
`default_nettype none
module amp_border (
    input  wire logic          i_clk,
    input  wire amp_pkg::t_cfg i_cfg,
    output amp_pkg::t_tbl      o_tbl
);

    amp_pkg::t_border                 n_rows;
    amp_pkg::t_border                 r_rows;
    logic [amp_pkg::StateW-1:0]       n_m;
    logic [amp_pkg::StateW-1:0]       r_m;

    // prefix-suffix table, one entry per (state, border length)
    always_comb begin
        n_rows = '0;
        for (int q = 0; q <= amp_pkg::MaxPattern; q++) begin
            for (int j = 0; j < amp_pkg::MaxPattern; j++) begin
                if (j <= q) begin
                    n_rows[q][j] = 1'b1;
                    for (int i = 0; i < j; i++) begin
                        if (i_cfg.pat[i] != i_cfg.pat[q - j + i]) begin
                            n_rows[q][j] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // effective pattern length, clamped to 1..MaxPattern
    always_comb begin
        if (i_cfg.len == '0) begin
            n_m = amp_pkg::StateW'(1);
        end else if (amp_pkg::StateW'(i_cfg.len) > amp_pkg::StateW'(amp_pkg::MaxPattern)) begin
            n_m = amp_pkg::StateW'(amp_pkg::MaxPattern);
        end else begin
            n_m = amp_pkg::StateW'(i_cfg.len);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows <= n_rows;
        r_m    <= n_m;
    end

    assign o_tbl.rows = r_rows;
    assign o_tbl.m    = r_m;

endmodule
`default_nettype wire

/* sv/amp_core.sv */
`default_nettype none
module amp_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire amp_pkg::t_cfg                i_cfg,
    input  wire amp_pkg::t_tbl                i_tbl,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [amp_pkg::ByteW-1:0]    i_text_byte,
    input  wire logic                         i_first,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_match_here,
    output logic      [amp_pkg::CountW-1:0]   o_match_count,
    output logic      [amp_pkg::StateW-1:0]   o_prefix_state
);

    logic                        r_in_valid;
    logic [amp_pkg::ByteW-1:0]   r_in_byte;
    logic                        r_in_first;

    logic [amp_pkg::StateW-1:0]  r_state;
    logic [amp_pkg::CountW-1:0]  r_count;

    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [amp_pkg::CountW-1:0]  r_out_count;
    logic [amp_pkg::StateW-1:0]  r_out_state;

    logic                        in_take;
    logic                        advance;
    logic [amp_pkg::StateW-1:0]  base_q;
    logic [amp_pkg::StateW-1:0]  kmax;
    amp_pkg::t_row               row;
    logic [amp_pkg::StateW-1:0]  n_state;
    logic [amp_pkg::CountW-1:0]  base_cnt;
    logic [amp_pkg::CountW-1:0]  n_count;
    logic                        hit;

    // handshake
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // automaton transition
    always_comb begin
        base_q = r_in_first ? '0 : r_state;
        if (base_q > i_tbl.m) begin
            base_q = '0;
        end
        kmax = (base_q < i_tbl.m) ? base_q + amp_pkg::StateW'(1) : i_tbl.m;
        row  = i_tbl.rows[base_q];

        // longest candidate wins
        n_state = '0;
        for (int k = 1; k <= amp_pkg::MaxPattern; k++) begin
            if ((amp_pkg::StateW'(k) <= kmax) && row[k-1]
                && (i_cfg.pat[k-1] == r_in_byte)) begin
                n_state = amp_pkg::StateW'(k);
            end
        end

        hit      = (n_state == i_tbl.m);
        base_cnt = r_in_first ? '0 : r_count;
        n_count  = (hit && (base_cnt != '1)) ? base_cnt + amp_pkg::CountW'(1) : base_cnt;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
        if (in_take) begin
            r_in_byte  <= i_text_byte;
            r_in_first <= i_first;
        end
    end

    // automaton state and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_count <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_hit   <= hit;
            r_out_count <= n_count;
            r_out_state <= n_state;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_match_here   = r_out_hit;
    assign o_match_count  = r_out_count;
    assign o_prefix_state = r_out_state;

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= amp_pkg::StateW'(amp_pkg::MaxPattern))
        else $error("prefix state beyond pattern size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_hit |-> r_out_state != '0)
        else $error("match reported with empty prefix");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_first && (r_count == '1) |=> r_count == '1)
        else $error("saturated count wrapped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("stall raised with room to move");

endmodule
`default_nettype wire

/* sv/automaton_pattern_matcher_unit.sv */
`default_nettype none
// Streaming pattern matcher: counts occurrences (overlaps included) of a pattern of 1 to 16
// bytes in a byte stream, one byte per request, with a saturating 32-bit count and the
// current matched-prefix length on every result. It sustains one byte per clock while the
// output is not stalled; each result passes the input register and then the result
// register on its way to the outputs, and that rate is set by the feedback of the prefix
// state through the transition logic.
// The prefix-suffix table is rebuilt from the pattern registers in the cycle after a
// register write, so a text byte may follow the write at the next edge.
// Registers sit at byte addresses 0 (pattern bytes 0-7), 8 (bytes 8-15) and 16 (length);
// the first flag on a request clears state and count before that byte.
module automaton_pattern_matcher_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [amp_pkg::AddrW-1:0]    paddr,
    input  wire logic [amp_pkg::DataW-1:0]    pwdata,
    output logic      [amp_pkg::DataW-1:0]    prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [amp_pkg::ByteW-1:0]    i_text_byte,
    input  wire logic                         i_first,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_match_here,
    output logic      [amp_pkg::CountW-1:0]   o_match_count,
    output logic      [amp_pkg::StateW-1:0]   o_prefix_state
);

    amp_pkg::t_cfg cfg;
    amp_pkg::t_tbl tbl;

    amp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    amp_border u_border (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .o_tbl (tbl)
    );

    amp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_tbl          (tbl),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .i_first        (i_first),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_match_here   (o_match_here),
        .o_match_count  (o_match_count),
        .o_prefix_state (o_prefix_state)
    );

endmodule
`default_nettype wire
